// ===== hw/rtl/calibrated_hsv_to_rgb_assert.svh =====
// Assertion macros for the calibrated HSV to RGB converter.
`ifndef CALIBRATED_HSV_TO_RGB_ASSERT_SVH
`define CALIBRATED_HSV_TO_RGB_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CHSV_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CHSV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`define CHSV_ASSERT_RESET(lbl, clk, rst, cons, msg) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);
`else
`define CHSV_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define CHSV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`define CHSV_ASSERT_RESET(lbl, clk, rst, cons, msg)
`endif
`endif

// ===== hw/rtl/chsv_pkg.sv =====
// Types, constants and level scaling functions of the calibrated HSV to RGB converter.
`timescale 1ns / 1ps
package chsv_pkg;

   typedef enum logic [1:0] {
      REG_USE_CALIBRATION  = 2'd0,
      REG_YELLOW_POSITION  = 2'd1,
      REG_CYAN_POSITION    = 2'd2,
      REG_MAGENTA_POSITION = 2'd3
   } csr_index_type;

   localparam int unsigned CSR_DATA_W = 13;

   localparam logic [8:0]  HUE_LAST    = 9'd359;
   localparam logic [8:0]  HUE_WRAP    = 9'd360;
   localparam logic [6:0]  PCT_FULL    = 7'd100;
   localparam logic [12:0] HUE_MUL     = 13'd17;
   // floor(a/15) == ((a+1)*273) >> 12 for a < 360
   localparam logic [8:0]  DIV15_RECIP = 9'd273;
   // floor(x*128/100) == (x*5243) >> 12 for x <= 100
   localparam logic [12:0] PCT_RECIP   = 13'd5243;

   localparam logic [12:0] SEG_STEP    = 13'd1024;
   localparam logic [10:0] D_ONE       = 11'd1024;
   localparam logic [7:0]  ONE_D7      = 8'd128;
   localparam logic [20:0] ONE_D20     = 21'h100000;
   localparam logic [7:0]  LEVEL_MAX   = 8'd255;

   localparam logic [10:0] YELLOW_RESET  = 11'h400;
   localparam logic [11:0] CYAN_RESET    = 12'hc00;
   localparam logic [12:0] MAGENTA_RESET = 13'h1400;
   localparam logic [11:0] CYAN_MIN      = 12'd2048;
   localparam logic [12:0] MAGENTA_MIN   = 13'd4096;
   localparam logic [12:0] MAGENTA_MAX   = 13'd6143;

   localparam logic [2:0] SEG_RED_YELLOW   = 3'd0;
   localparam logic [2:0] SEG_YELLOW_GREEN = 3'd1;
   localparam logic [2:0] SEG_GREEN_CYAN   = 3'd2;
   localparam logic [2:0] SEG_CYAN_BLUE    = 3'd3;
   localparam logic [2:0] SEG_BLUE_MAGENTA = 3'd4;
   localparam logic [2:0] SEG_LAST         = 3'd5;

   function automatic logic [7:0] scale_d7(input logic [7:0] b);
      return (b >= ONE_D7) ? LEVEL_MAX : {b[6:0], 1'b0};
   endfunction

   function automatic logic [7:0] scale_d10(input logic [10:0] b);
      return (b >= D_ONE) ? LEVEL_MAX : b[9:2];
   endfunction

endpackage

// ===== hw/rtl/calibrated_hsv_to_rgb.sv =====
// Calibrated HSV to RGB converter: five-stage pipeline with valid/ready flow control.
// Converts hue (degrees), saturation and value (percent) to 8-bit red, green and blue
// levels. One item is taken per clock while the first stage can advance; each result passes
// through the five register stages in order (input scaling, calibration multiply, segment
// and level products, partner product, routing into the output register).
// A stalled output backs up only as far as the stages are full, so empty stages keep
// accepting items. The calibration registers are read by the item in the second stage, so
// write them only while no item is in flight.
`timescale 1ns / 1ps
`include "calibrated_hsv_to_rgb_assert.svh"
module calibrated_hsv_to_rgb (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [8:0]                           req_hue_degrees,
   input  logic [6:0]                           req_saturation_percent,
   input  logic [6:0]                           req_value_percent,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [7:0]                           rsp_red,
   output logic [7:0]                           rsp_green,
   output logic [7:0]                           rsp_blue,
   input  logic                                 csr_write_enable,
   input  chsv_pkg::csr_index_type              csr_index,
   input  logic [chsv_pkg::CSR_DATA_W-1:0]      csr_write_data
);
   import chsv_pkg::*;

   logic        use_cal_ff;
   logic [10:0] yellow_ff;
   logic [11:0] cyan_ff;
   logic [12:0] magenta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_cal_ff <= 1'b1;
         yellow_ff  <= YELLOW_RESET;
         cyan_ff    <= CYAN_RESET;
         magenta_ff <= MAGENTA_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_USE_CALIBRATION:  use_cal_ff <= csr_write_data[0];
            REG_YELLOW_POSITION:  yellow_ff  <= csr_write_data[10:0];
            REG_CYAN_POSITION:    cyan_ff    <= csr_write_data[11:0];
            REG_MAGENTA_POSITION: magenta_ff <= csr_write_data[12:0];
         endcase
      end
   end

   // flow control
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, rsp_valid_ff;
   logic ld1, ld2, ld3, ld4, ld5;

   assign ld5 = !rsp_valid_ff || rsp_ready;
   assign ld4 = !s4_vld_ff || ld5;
   assign ld3 = !s3_vld_ff || ld4;
   assign ld2 = !s2_vld_ff || ld3;
   assign ld1 = !s1_vld_ff || ld2;
   assign req_ready = ld1;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         s4_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ld1) s1_vld_ff    <= req_valid;
         if (ld2) s2_vld_ff    <= s1_vld_ff;
         if (ld3) s3_vld_ff    <= s2_vld_ff;
         if (ld4) s4_vld_ff    <= s3_vld_ff;
         if (ld5) rsp_valid_ff <= s4_vld_ff;
      end
   end

   // stage 1: wrap, clip, fixed-point scaling
   logic [8:0]  hue_w;
   logic [9:0]  hue_p1;
   logic [18:0] div_prod;
   logic [12:0] hue_in;
   logic [6:0]  sat_c, val_c;
   logic [19:0] sat_prod, val_prod;
   logic [12:0] s1_hue_ff;
   logic [7:0]  s1_sat_ff, s1_val_ff;

   always_comb begin
      hue_w    = (req_hue_degrees > HUE_LAST) ? req_hue_degrees - HUE_WRAP : req_hue_degrees;
      hue_p1   = {1'b0, hue_w} + 10'd1;
      div_prod = 19'(hue_p1) * 19'(DIV15_RECIP);
      hue_in   = 13'(hue_w) * HUE_MUL + 13'(div_prod[16:12]);
      sat_c    = (req_saturation_percent > PCT_FULL) ? PCT_FULL : req_saturation_percent;
      val_c    = (req_value_percent > PCT_FULL) ? PCT_FULL : req_value_percent;
      sat_prod = 20'(sat_c) * 20'(PCT_RECIP);
      val_prod = 20'(val_c) * 20'(PCT_RECIP);
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         s1_hue_ff <= hue_in;
         s1_sat_ff <= sat_prod[19:12];
         s1_val_ff <= val_prod[19:12];
      end
   end

   // stage 2: calibration product
   logic [11:0] cyan_c;
   logic [12:0] magenta_c;
   logic [2:0]  seg_in;
   logic [12:0] base, pos, off_in, span;
   logic [11:0] diff;
   logic [21:0] cal_prod;
   logic [12:0] s2_off_ff;
   logic [21:0] s2_prod_ff;
   logic [7:0]  s2_sat_ff, s2_val_ff;

   always_comb begin
      cyan_c = (cyan_ff < CYAN_MIN) ? CYAN_MIN : cyan_ff;
      if (magenta_ff < MAGENTA_MIN) begin
         magenta_c = MAGENTA_MIN;
      end else if (magenta_ff > MAGENTA_MAX) begin
         magenta_c = MAGENTA_MAX;
      end else begin
         magenta_c = magenta_ff;
      end
      seg_in = s1_hue_ff[12:10];
      base   = {seg_in, 10'd0};
      unique case (seg_in[2:1])
         2'd0:    pos = 13'(yellow_ff);
         2'd1:    pos = 13'(cyan_c);
         default: pos = magenta_c;
      endcase
      if (!use_cal_ff || seg_in > SEG_LAST) begin
         off_in = s1_hue_ff;
         span   = 13'd0;
      end else if (!seg_in[0]) begin
         off_in = base;
         span   = pos - base;
      end else begin
         off_in = pos;
         span   = base + SEG_STEP - pos;
      end
      diff     = span[11:0];
      cal_prod = 22'(s1_hue_ff[9:0]) * 22'(diff);
   end

   always_ff @(posedge clock) begin
      if (ld2) begin
         s2_off_ff  <= off_in;
         s2_prod_ff <= cal_prod;
         s2_sat_ff  <= s1_sat_ff;
         s2_val_ff  <= s1_val_ff;
      end
   end

   // stage 3: final hue, segment distance and white level
   logic [12:0] hue_cal;
   logic [10:0] seg_dist;
   logic [17:0] sd_prod;
   logic [15:0] white_prod;
   logic [2:0]  s3_seg_ff;
   logic [17:0] s3_sd_ff;
   logic [7:0]  s3_white_ff, s3_val_ff;

   always_comb begin
      hue_cal    = s2_off_ff + 13'(s2_prod_ff[21:10]);
      seg_dist   = hue_cal[10] ? {1'b0, hue_cal[9:0]} : D_ONE - {1'b0, hue_cal[9:0]};
      sd_prod    = 18'(s2_sat_ff) * 18'(seg_dist);
      white_prod = 16'(s2_val_ff) * 16'(ONE_D7 - s2_sat_ff);
   end

   always_ff @(posedge clock) begin
      if (ld3) begin
         s3_seg_ff   <= hue_cal[12:10];
         s3_sd_ff    <= sd_prod;
         s3_white_ff <= white_prod[14:7];
         s3_val_ff   <= s2_val_ff;
      end
   end

   // stage 4: partner level
   logic [20:0] pfrac;
   logic [30:0] par_prod;
   logic [2:0]  s4_seg_ff;
   logic [10:0] s4_par_ff;
   logic [7:0]  s4_dom_ff, s4_wht_ff;

   always_comb begin
      pfrac    = ONE_D20 - {s3_sd_ff, 3'd0};
      par_prod = 31'({s3_val_ff, 3'd0}) * 31'(pfrac);
   end

   always_ff @(posedge clock) begin
      if (ld4) begin
         s4_seg_ff <= s3_seg_ff;
         s4_par_ff <= par_prod[30:20];
         s4_dom_ff <= scale_d7(s3_val_ff);
         s4_wht_ff <= scale_d7(s3_white_ff);
      end
   end

   // stage 5: route levels to channels
   logic [7:0] par;
   logic [7:0] red_in, green_in, blue_in;
   logic [7:0] red_ff, green_ff, blue_ff;

   always_comb begin
      par = scale_d10(s4_par_ff);
      unique case (s4_seg_ff)
         SEG_RED_YELLOW: begin
            red_in = s4_dom_ff; green_in = par; blue_in = s4_wht_ff;
         end
         SEG_YELLOW_GREEN: begin
            red_in = par; green_in = s4_dom_ff; blue_in = s4_wht_ff;
         end
         SEG_GREEN_CYAN: begin
            red_in = s4_wht_ff; green_in = s4_dom_ff; blue_in = par;
         end
         SEG_CYAN_BLUE: begin
            red_in = s4_wht_ff; green_in = par; blue_in = s4_dom_ff;
         end
         SEG_BLUE_MAGENTA: begin
            red_in = par; green_in = s4_wht_ff; blue_in = s4_dom_ff;
         end
         default: begin
            red_in = s4_dom_ff; green_in = s4_wht_ff; blue_in = par;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ld5) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

   `CHSV_ASSERT_RESET(a_reset_flush, clock, reset, !s1_vld_ff && !s2_vld_ff && !s3_vld_ff && !s4_vld_ff && !rsp_valid_ff, "pipeline not empty after reset")
   `CHSV_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && req_ready, s1_vld_ff, "accepted item missing from first stage")
   `CHSV_ASSERT_IMP(a_full_stall, clock, reset, s1_vld_ff && s2_vld_ff && s3_vld_ff && s4_vld_ff && rsp_valid_ff && !rsp_ready, !req_ready, "item taken while pipeline full and stalled")
   `CHSV_ASSERT_IMP(a_hue_range, clock, reset, s3_vld_ff, s3_seg_ff <= SEG_LAST, "calibrated hue beyond last segment")

endmodule

// ===== tb/calibrated_hsv_to_rgb_test.sv =====
// Self-checking testbench for the calibrated HSV to RGB converter with random flow control.
`timescale 1ns / 1ps
module calibrated_hsv_to_rgb_test;
   import chsv_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int LONG_HOLD      = 80;
   localparam int HOLD_AFTER     = 140;
   localparam int PHASES         = 10;
   localparam int PHASE_ITEMS    = 52;

   typedef struct packed {
      logic [8:0] hue;
      logic [6:0] sat;
      logic [6:0] val;
   } hsv_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [8:0]            req_hue_degrees;
   logic [6:0]            req_saturation_percent;
   logic [6:0]            req_value_percent;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [7:0]            rsp_red;
   logic [7:0]            rsp_green;
   logic [7:0]            rsp_blue;
   logic                  csr_write_enable;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   // shadow of the calibration registers
   logic        cal_enable;
   logic [10:0] yellow_pos;
   logic [11:0] cyan_pos;
   logic [12:0] magenta_pos;

   hsv_type pixels_to_send[$];
   rgb_type rgb_expected[$];
   hsv_type next_pixel;
   rgb_type got_rgb;
   rgb_type want_rgb;
   bit   req_accepted;
   bit   idle_bursts;
   bit   long_hold_done;
   bit   progress;
   int   send_gap;
   int   stall_left;
   int   items_accepted;
   int   idle_cycles;
   int   mismatches;
   int   phase;

   calibrated_hsv_to_rgb u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_hue_degrees        (req_hue_degrees),
      .req_saturation_percent (req_saturation_percent),
      .req_value_percent      (req_value_percent),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_red                (rsp_red),
      .rsp_green              (rsp_green),
      .rsp_blue               (rsp_blue),
      .csr_write_enable       (csr_write_enable),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic logic [7:0] drive_from_d7(input int unsigned level);
      return (level >= 128) ? 8'd255 : 8'((level << 1) & 8'hff);
   endfunction

   function automatic rgb_type convert_pixel(input hsv_type px);
      int unsigned      angle;
      int unsigned      sat_pct;
      int unsigned      val_pct;
      int unsigned      hue;
      int unsigned      sat;
      int unsigned      val;
      int unsigned      seg;
      int unsigned      frac;
      int unsigned      base;
      int unsigned      anchor;
      int unsigned      white;
      int unsigned      seg_dist;
      int unsigned      share;
      longint unsigned  partner;
      logic [7:0]       full_lvl;
      logic [7:0]       white_lvl;
      logic [7:0]       partner_lvl;
      rgb_type          rgb;
      angle   = px.hue;
      sat_pct = px.sat;
      val_pct = px.val;
      if (angle > 359) angle = angle - 360;
      if (sat_pct > 100) sat_pct = 100;
      if (val_pct > 100) val_pct = 100;
      hue = angle * 17 + angle / 15;
      sat = (sat_pct << 7) / 100;
      val = (val_pct << 7) / 100;
      if (cal_enable) begin
         seg  = (hue >> 10) & 7;
         frac = hue & 32'h3ff;
         base = seg * 1024;
         if (seg < 2) begin
            anchor = yellow_pos;
         end else if (seg < 4) begin
            anchor = (cyan_pos < 2048) ? 2048 : cyan_pos;
         end else begin
            anchor = (magenta_pos < 4096) ? 4096 : (magenta_pos > 6143) ? 6143 : magenta_pos;
         end
         if (seg <= 5) begin
            if (seg % 2 == 0) hue = base + ((frac * (anchor - base)) >> 10);
            else hue = anchor + ((frac * (base + 1024 - anchor)) >> 10);
         end
      end
      seg      = (hue >> 10) & 7;
      frac     = hue & 32'h3ff;
      white    = (val * (128 - sat)) >> 7;
      seg_dist = (seg % 2 == 0) ? (1024 - frac) : frac;
      share    = 32'h100000 - (sat << 3) * seg_dist;
      partner  = (longint'(val << 3) * longint'(share)) >> 20;
      full_lvl    = drive_from_d7(val);
      white_lvl   = drive_from_d7(white);
      partner_lvl = (partner >= 1024) ? 8'd255 : 8'((partner >> 2) & 8'hff);
      case (seg)
         0: rgb = {full_lvl, partner_lvl, white_lvl};
         1: rgb = {partner_lvl, full_lvl, white_lvl};
         2: rgb = {white_lvl, full_lvl, partner_lvl};
         3: rgb = {white_lvl, partner_lvl, full_lvl};
         4: rgb = {partner_lvl, white_lvl, full_lvl};
         default: rgb = {full_lvl, white_lvl, partner_lvl};
      endcase
      return rgb;
   endfunction

   function automatic logic [6:0] pick_percent();
      case ($urandom_range(0, 7))
         0: return 7'd0;
         1: return 7'd100;
         2: return 7'($urandom_range(101, 127));
         default: return 7'($urandom_range(0, 100));
      endcase
   endfunction

   task automatic queue_pixel(input logic [8:0] hue, input logic [6:0] sat,
                              input logic [6:0] val);
      hsv_type px;
      px = {hue, sat, val};
      pixels_to_send.push_back(px);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         REG_USE_CALIBRATION:  cal_enable  = data[0];
         REG_YELLOW_POSITION:  yellow_pos  = data[10:0];
         REG_CYAN_POSITION:    cyan_pos    = data[11:0];
         REG_MAGENTA_POSITION: magenta_pos = data[12:0];
         default: ;
      endcase
   endtask

   task automatic set_calibration(input logic cal, input logic [10:0] yellow,
                                  input logic [11:0] cyan, input logic [12:0] magenta);
      write_csr(REG_USE_CALIBRATION, CSR_DATA_W'(cal));
      write_csr(REG_YELLOW_POSITION, CSR_DATA_W'(yellow));
      write_csr(REG_CYAN_POSITION, CSR_DATA_W'(cyan));
      write_csr(REG_MAGENTA_POSITION, CSR_DATA_W'(magenta));
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic wait_for_idle();
      while (pixels_to_send.size() != 0 || req_valid || rgb_expected.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic check_level(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // sender: holds each item until accepted, random gaps between items
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         req_accepted = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (idle_bursts && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 11);
            req_valid <= 1'b0;
         end else if (pixels_to_send.size() != 0) begin
            next_pixel = pixels_to_send.pop_front();
            req_hue_degrees        <= next_pixel.hue;
            req_saturation_percent <= next_pixel.sat;
            req_value_percent      <= next_pixel.val;
            req_valid              <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls plus one long hold-off to back up the pipeline
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!long_hold_done && items_accepted >= HOLD_AFTER) begin
         long_hold_done = 1'b1;
         stall_left = LONG_HOLD - 1;
         rsp_ready <= 1'b0;
      end else if (idle_bursts && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 11);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         progress = csr_write_enable;
         if (req_valid && req_ready) begin
            rgb_expected.push_back(convert_pixel({req_hue_degrees, req_saturation_percent,
                                                  req_value_percent}));
            req_accepted = 1'b1;
            items_accepted++;
            progress = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            progress = 1'b1;
            got_rgb  = {rsp_red, rsp_green, rsp_blue};
            if (rgb_expected.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected item, expected none, actual r=%0d g=%0d b=%0d",
                        $time, got_rgb.red, got_rgb.green, got_rgb.blue);
            end else begin
               want_rgb = rgb_expected.pop_front();
               check_level("red", want_rgb.red, got_rgb.red);
               check_level("green", want_rgb.green, got_rgb.green);
               check_level("blue", want_rgb.blue, got_rgb.blue);
            end
         end
         if (progress) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("calibrated_hsv_to_rgb test failed");
            $finish;
         end
      end
   end

   initial begin
      clock                  = 1'b0;
      reset                  = 1'b1;
      req_valid              = 1'b0;
      req_hue_degrees        = '0;
      req_saturation_percent = '0;
      req_value_percent      = '0;
      rsp_ready              = 1'b0;
      csr_write_enable       = 1'b0;
      csr_index              = REG_USE_CALIBRATION;
      csr_write_data         = '0;
      cal_enable             = 1'b1;
      yellow_pos             = 11'd1024;
      cyan_pos               = 12'd3072;
      magenta_pos            = 13'd5120;
      idle_bursts            = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // corners, segment boundaries, hue wrap and percent clipping
      queue_pixel(9'd0, 7'd100, 7'd100);
      queue_pixel(9'd359, 7'd100, 7'd100);
      queue_pixel(9'd360, 7'd100, 7'd100);
      queue_pixel(9'd511, 7'd100, 7'd100);
      queue_pixel(9'd60, 7'd100, 7'd100);
      queue_pixel(9'd120, 7'd100, 7'd100);
      queue_pixel(9'd180, 7'd100, 7'd100);
      queue_pixel(9'd240, 7'd100, 7'd100);
      queue_pixel(9'd300, 7'd100, 7'd100);
      queue_pixel(9'd59, 7'd100, 7'd100);
      queue_pixel(9'd61, 7'd75, 7'd75);
      queue_pixel(9'd30, 7'd50, 7'd80);
      queue_pixel(9'd90, 7'd100, 7'd100);
      queue_pixel(9'd150, 7'd0, 7'd100);
      queue_pixel(9'd210, 7'd100, 7'd0);
      queue_pixel(9'd270, 7'd101, 7'd127);
      queue_pixel(9'd330, 7'd127, 7'd100);
      queue_pixel(9'd1, 7'd1, 7'd1);
      queue_pixel(9'd419, 7'd100, 7'd100);
      queue_pixel(9'd100, 7'd127, 7'd127);
      queue_pixel(9'd200, 7'd64, 7'd32);
      queue_pixel(9'd0, 7'd0, 7'd0);
      queue_pixel(9'd45, 7'd100, 7'd100);
      queue_pixel(9'd255, 7'd33, 7'd67);
      wait_for_idle();

      for (phase = 1; phase <= PHASES; phase++) begin
         case (phase)
            1: set_calibration(1'b0, 11'd1024, 12'd3072, 13'd5120);
            2: set_calibration(1'b1, 11'd0, 12'd2048, 13'd4096);
            3: set_calibration(1'b1, 11'd2047, 12'd4095, 13'd6143);
            4: set_calibration(1'b1, 11'd1024, 12'd0, 13'd8191);
            5: set_calibration(1'b1, 11'd500, 12'd2047, 13'd4095);
            6: set_calibration(1'b1, 11'd1800, 12'd3000, 13'd6144);
            default: set_calibration(1'($urandom_range(0, 1)), 11'($urandom_range(0, 2047)),
                        12'($urandom_range(0, 1) ? $urandom_range(2048, 4095)
                                                 : $urandom_range(0, 4095)),
                        13'($urandom_range(0, 1) ? $urandom_range(4096, 6143)
                                                 : $urandom_range(0, 8191)));
         endcase
         idle_bursts = (phase != PHASES);
         repeat (PHASE_ITEMS)
            queue_pixel(($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                                    : 9'($urandom_range(0, 359)),
                        pick_percent(), pick_percent());
         wait_for_idle();
      end

      if (mismatches == 0 && rgb_expected.size() == 0) begin
         $display("calibrated_hsv_to_rgb test passed");
      end else begin
         $display("calibrated_hsv_to_rgb test failed");
      end
      $finish;
   end

endmodule
